// ----- sv/shs_pkg.sv -----
// ----------------------------------------------------------------------------
// shs_pkg
// Shared types, constants and round functions for the SHA-256 byte stream
// hasher: controller states, datapath commands and the SHA-256 tables.
// ----------------------------------------------------------------------------
package shs_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LEN,
		ST_RND,
		ST_ADD,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		SEL_INPUT,
		SEL_MARK,
		SEL_ZERO,
		SEL_LEN
	} byte_sel_t;

	typedef struct packed {
		logic      push;
		byte_sel_t sel;
		logic      count_msg;
		logic [2:0] len_idx;
		logic      load_work;
		logic      round_en;
		logic [5:0] rnd;
		logic      add_chain;
		logic      finish;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} status_t;

	localparam logic [5:0] BLOCK_LAST_BYTE = 6'd63;
	localparam logic [5:0] PAD_LAST_BYTE   = 6'd55;
	localparam logic [5:0] ROUND_LAST      = 6'd63;
	localparam logic [2:0] LEN_LAST        = 3'd7;
	localparam logic [2:0] WORD_LAST       = 3'd7;
	localparam logic [7:0] PAD_MARK        = 8'h80;

	localparam logic [0:7][31:0] INIT_H = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [0:63][31:0] ROUND_K = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

// ----- sv/shs_ctrl.sv -----
// ----------------------------------------------------------------------------
// shs_ctrl
// Controller: accepts input words, tracks the block fill level, sequences
// padding, the length field, the 64 compression rounds and the digest hand-off.
// ----------------------------------------------------------------------------
module shs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             has_byte,
	input  logic             end_of_message,
	input  shs_pkg::status_t status,
	output shs_pkg::cmd_t    cmd
);

	shs_pkg::state_t state_q, state_d;
	shs_pkg::state_t ret_q;
	logic            eom_q;
	logic            pad_first_q;
	logic [5:0]      fill_q;
	logic [5:0]      rnd_q;
	logic [2:0]      len_idx_q;
	logic            accept;

	assign accept = in_valid && in_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			shs_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (has_byte && fill_q == shs_pkg::BLOCK_LAST_BYTE) begin
						state_d = shs_pkg::ST_RND;
					end else if (end_of_message) begin
						state_d = shs_pkg::ST_PAD;
					end
				end
			end
			shs_pkg::ST_PAD: begin
				if (fill_q == shs_pkg::BLOCK_LAST_BYTE) begin
					state_d = shs_pkg::ST_RND;
				end else if (fill_q == shs_pkg::PAD_LAST_BYTE) begin
					state_d = shs_pkg::ST_LEN;
				end
			end
			shs_pkg::ST_LEN: begin
				if (len_idx_q == shs_pkg::LEN_LAST) begin
					state_d = shs_pkg::ST_RND;
				end
			end
			shs_pkg::ST_RND: begin
				if (rnd_q == shs_pkg::ROUND_LAST) begin
					state_d = shs_pkg::ST_ADD;
				end
			end
			shs_pkg::ST_ADD: begin
				case (ret_q)
					shs_pkg::ST_IDLE: state_d = eom_q ? shs_pkg::ST_PAD : shs_pkg::ST_IDLE;
					shs_pkg::ST_PAD:  state_d = shs_pkg::ST_PAD;
					shs_pkg::ST_LEN:  state_d = shs_pkg::ST_FIN;
					default:          state_d = shs_pkg::ST_IDLE;
				endcase
			end
			shs_pkg::ST_FIN: begin
				if (!status.out_busy) begin
					state_d = shs_pkg::ST_IDLE;
				end
			end
			default: state_d = shs_pkg::ST_IDLE;
		endcase
	end

	// Outputs and datapath commands.
	always_comb begin
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.sel       = shs_pkg::SEL_INPUT;
		cmd.rnd       = rnd_q;
		cmd.len_idx   = len_idx_q;
		case (state_q)
			shs_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.push      = in_valid && has_byte;
				cmd.count_msg = in_valid && has_byte;
			end
			shs_pkg::ST_PAD: begin
				cmd.push = 1'b1;
				cmd.sel  = pad_first_q ? shs_pkg::SEL_MARK : shs_pkg::SEL_ZERO;
			end
			shs_pkg::ST_LEN: begin
				cmd.push = 1'b1;
				cmd.sel  = shs_pkg::SEL_LEN;
			end
			shs_pkg::ST_RND: begin
				cmd.round_en = 1'b1;
			end
			shs_pkg::ST_ADD: begin
				cmd.add_chain = 1'b1;
			end
			shs_pkg::ST_FIN: begin
				cmd.finish = !status.out_busy;
			end
			default: begin
				cmd.push = 1'b0;
			end
		endcase
		// The byte that completes a block also loads the working variables.
		cmd.load_work = cmd.push && fill_q == shs_pkg::BLOCK_LAST_BYTE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= shs_pkg::ST_IDLE;
			ret_q       <= shs_pkg::ST_IDLE;
			eom_q       <= 1'b0;
			pad_first_q <= 1'b0;
			fill_q      <= '0;
			rnd_q       <= '0;
			len_idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.push) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.load_work) begin
				ret_q <= state_q;
			end
			if (accept && end_of_message) begin
				eom_q       <= 1'b1;
				pad_first_q <= 1'b1;
			end else if (state_q == shs_pkg::ST_PAD) begin
				pad_first_q <= 1'b0;
			end
			if (cmd.finish) begin
				eom_q <= 1'b0;
			end
			rnd_q     <= (state_q == shs_pkg::ST_RND) ? rnd_q + 6'd1 : 6'd0;
			len_idx_q <= (state_q == shs_pkg::ST_LEN) ? len_idx_q + 3'd1 : 3'd0;
		end
	end

endmodule

// ----- sv/shs_datapath.sv -----
// ----------------------------------------------------------------------------
// shs_datapath
// Datapath: 512-bit block shift register that doubles as the message
// schedule window, one-round-per-cycle compression, chaining words, message
// length counter and the digest output register.
// ----------------------------------------------------------------------------
module shs_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  shs_pkg::cmd_t     cmd,
	output shs_pkg::status_t  status,
	input  logic [7:0]        data_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       digest_word,
	output logic [2:0]        word_index,
	output logic              last_word
);

	logic [511:0]      blk_q;
	logic [7:0][31:0]  work_q;
	logic [7:0][31:0]  chain_q;
	logic [7:0][31:0]  dig_q;
	logic [63:0]       len_q;
	logic              out_busy_q;
	logic [2:0]        out_idx_q;

	logic [63:0] len_bits;
	logic [2:0]  len_sel;
	logic [7:0]  push_byte;
	logic [31:0] w0, w1, w9, w14, w_new;
	logic [31:0] t1, t2;
	logic        out_accept;

	assign len_bits = {len_q[60:0], 3'b000};
	assign len_sel  = 3'd7 - cmd.len_idx;

	always_comb begin
		case (cmd.sel)
			shs_pkg::SEL_INPUT: push_byte = data_byte;
			shs_pkg::SEL_MARK:  push_byte = shs_pkg::PAD_MARK;
			shs_pkg::SEL_ZERO:  push_byte = 8'h00;
			shs_pkg::SEL_LEN:   push_byte = len_bits[{len_sel, 3'b000} +: 8];
			default:            push_byte = 8'h00;
		endcase
	end

	// The window holds schedule words t..t+15, oldest in the top word.
	assign w0  = blk_q[511:480];
	assign w1  = blk_q[479:448];
	assign w9  = blk_q[223:192];
	assign w14 = blk_q[63:32];
	assign w_new = shs_pkg::small_sigma1(w14) + w9 + shs_pkg::small_sigma0(w1) + w0;

	// Index 0 is a, index 7 is h.
	assign t1 = work_q[7] + shs_pkg::big_sigma1(work_q[4])
		+ ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
		+ shs_pkg::ROUND_K[cmd.rnd] + w0;
	assign t2 = shs_pkg::big_sigma0(work_q[0])
		+ ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			blk_q <= {blk_q[503:0], push_byte};
		end else if (cmd.round_en) begin
			blk_q <= {blk_q[479:0], w_new};
		end
		if (cmd.load_work) begin
			work_q <= chain_q;
		end else if (cmd.round_en) begin
			work_q <= {work_q[6:4], work_q[3] + t1, work_q[2:0], t1 + t2};
		end
		if (cmd.finish) begin
			dig_q <= chain_q;
		end else if (out_accept) begin
			dig_q <= {32'h0, dig_q[7:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= shs_pkg::INIT_H[i];
			end
			len_q      <= '0;
			out_busy_q <= 1'b0;
			out_idx_q  <= '0;
		end else begin
			if (cmd.finish) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= shs_pkg::INIT_H[i];
				end
				len_q <= '0;
			end else begin
				if (cmd.add_chain) begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + work_q[i];
					end
				end
				if (cmd.count_msg) begin
					len_q <= len_q + 64'd1;
				end
			end
			if (cmd.finish) begin
				out_busy_q <= 1'b1;
				out_idx_q  <= '0;
			end else if (out_accept) begin
				out_idx_q <= out_idx_q + 3'd1;
				if (out_idx_q == shs_pkg::WORD_LAST) begin
					out_busy_q <= 1'b0;
				end
			end
		end
	end

	assign out_accept      = out_busy_q && out_ready;
	assign out_valid       = out_busy_q;
	assign digest_word     = dig_q[0];
	assign word_index      = out_idx_q;
	assign last_word       = out_idx_q == shs_pkg::WORD_LAST;
	assign status.out_busy = out_busy_q;

endmodule

// ----- sv/sha256_byte_stream_hasher_unit.sv -----
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_unit
// SHA-256 over a byte stream: at most one message byte per input word, eight digest
// words out after each end of message.
// ----------------------------------------------------------------------------
// A message byte is taken while the unit is idle; the byte that completes a
// 64-byte block holds the input through the 64 rounds on the single round
// unit and the chaining add. End of message inserts 9 to 72 padding and length
// bytes one per cycle, pausing for each compression; one or two compressions follow.
// Digest words follow one per cycle while the consumer is ready.
// Reset loads the initial hash values and clears the length; block bytes are not cleared.
module sha256_byte_stream_hasher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	shs_pkg::cmd_t    cmd;
	shs_pkg::status_t status;

	shs_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.has_byte       (has_byte),
		.end_of_message (end_of_message),
		.status         (status),
		.cmd            (cmd)
	);

	shs_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

	// An accepted end-of-message word leads to padding or a compression, so the input closes.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && end_of_message) |=> !in_ready)
		else $error("input still open after end of message");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (word_index == 3'd0))
		else $error("digest does not start at word zero");

	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready && last_word))
		else $error("digest output ended before the last word");

endmodule

// ----- sim/sha256_digest_check.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256_digest_check
// Passive checker for the SHA-256 byte stream hasher. It follows every word
// accepted on the input channel with its own SHA-256 model, queues the eight
// digest words that each end of message must produce, and compares every
// accepted output word against the oldest queued one.
// ----------------------------------------------------------------------------
module sha256_digest_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] digest_word,
	input  logic [2:0]  word_index,
	input  logic        last_word,
	output int          fail_count,
	output int          pending_words
);

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_entry_t;

	localparam logic [7:0] MARK_BYTE       = 8'h80;
	localparam logic [5:0] LEN_FIELD_START = 6'd56;

	localparam logic [0:7][31:0] START_CHAIN = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [0:63][31:0] ROUND_CONST = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	logic [31:0]   chain [8];
	logic [7:0]    blk [64];
	logic [63:0]   msg_bytes;
	digest_entry_t digest_due [$];

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		logic [63:0] xx;
		xx = {x, x} >> n;
		return xx[31:0];
	endfunction

	task automatic compress_chain();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = s1 + w[i-7] + s0 + w[i-16];
		end
		for (int i = 0; i < 8; i++)
			v[i] = chain[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + w[i];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] = chain[i] + v[i];
	endtask

	task automatic absorb(input logic [7:0] b);
		blk[msg_bytes[5:0]] = b;
		msg_bytes = msg_bytes + 64'd1;
		if (msg_bytes[5:0] == 6'd0)
			compress_chain();
	endtask

	task automatic restart();
		for (int i = 0; i < 8; i++)
			chain[i] = START_CHAIN[i];
		msg_bytes = '0;
	endtask

	// Padding runs until the block position reaches the length field, which
	// spills into a second block when the mark lands past byte 55.
	task automatic close_message();
		logic [63:0] bit_len;
		bit_len = msg_bytes << 3;
		absorb(MARK_BYTE);
		while (msg_bytes[5:0] != LEN_FIELD_START)
			absorb(8'h00);
		for (int i = 0; i < 8; i++)
			absorb(bit_len[63 - 8*i -: 8]);
		for (int i = 0; i < 8; i++)
			digest_due.push_back(digest_entry_t'{chain[i], 3'(i), (i == 7)});
		restart();
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		digest_entry_t want;
		if (!arst_n) begin
			restart();
			digest_due.delete();
			fail_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (digest_due.size() == 0) begin
					$error("digest_word %h arrived with no word expected", digest_word);
					fail_count++;
				end else begin
					want = digest_due.pop_front();
					if (digest_word !== want.word) begin
						$error("digest_word: expected %h, got %h", want.word, digest_word);
						fail_count++;
					end
					if (word_index !== want.index) begin
						$error("word_index: expected %0d, got %0d", want.index, word_index);
						fail_count++;
					end
					if (last_word !== want.last) begin
						$error("last_word: expected %0d, got %0d", want.last, last_word);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (has_byte)
					absorb(data_byte);
				if (end_of_message)
					close_message();
			end
		end
		pending_words = digest_due.size();
	end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Top of the SHA-256 byte stream hasher testbench. It sends short directed
// messages and then random messages of varied length, with bursts and gaps
// on the input side and random stalls on the output side, while the digest
// checker predicts and compares every output word.
// ----------------------------------------------------------------------------
module tb;

	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 300;
	localparam int ITEM_TARGET = 250;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        has_byte = 1'b0;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	int fail_count;
	int pending_words;
	int burst_left = 0;
	int ready_hold = 0;
	int idle_cycles = 0;

	sha256_byte_stream_hasher_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.has_byte       (has_byte),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.digest_word    (digest_word),
		.word_index     (word_index),
		.last_word      (last_word)
	);

	sha256_digest_check u_digest_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.has_byte       (has_byte),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.digest_word    (digest_word),
		.word_index     (word_index),
		.last_word      (last_word),
		.fail_count     (fail_count),
		.pending_words  (pending_words)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The receiver holds each ready level for a random run of cycles.
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			ready_hold <= $urandom_range(0, 15);
			out_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offers one word and returns at the edge where it is taken. The ready
	// level is read at the falling edge, where it is settled.
	task automatic send_word(input logic [7:0] b, input logic hb, input logic eom);
		logic rdy;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 20);
		end
		burst_left--;
		in_valid <= 1'b1;
		data_byte <= b;
		has_byte <= hb;
		end_of_message <= eom;
		do begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
		end while (!rdy);
	endtask

	initial begin
		int sent;
		int len;
		int pick;
		logic tail_byte;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty message, ignored bytes and idle words, then short messages.
		send_word(8'h3c, 1'b0, 1'b1);
		send_word(8'hff, 1'b0, 1'b0);
		send_word(8'h00, 1'b0, 1'b0);
		send_word(8'h61, 1'b1, 1'b0);
		send_word(8'h62, 1'b1, 1'b0);
		send_word(8'h63, 1'b1, 1'b1);
		send_word(8'hff, 1'b1, 1'b1);
		send_word(8'h00, 1'b1, 1'b1);
		send_word(8'h00, 1'b1, 1'b0);
		send_word(8'hff, 1'b1, 1'b0);
		send_word(8'h5a, 1'b0, 1'b1);

		// Lengths cluster near the block and padding boundaries. The last
		// message is cut short so the total stays near the target.
		sent = 0;
		while (sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 9);
			if (pick <= 5)
				len = $urandom_range(0, 20);
			else if (pick == 6)
				len = 55 + $urandom_range(0, 1) + 8 * $urandom_range(0, 1);
			else if (pick == 7)
				len = $urandom_range(50, 70);
			else if (pick == 8)
				len = 119 + $urandom_range(0, 1) + 8 * $urandom_range(0, 1);
			else
				len = $urandom_range(0, 130);
			if (len > ITEM_TARGET - sent - 1)
				len = ITEM_TARGET - sent - 1;
			tail_byte = (len > 0) && ($urandom_range(0, 1) == 1);
			for (int i = 0; i < len - int'(tail_byte); i++) begin
				if ($urandom_range(0, 7) == 0) begin
					send_word(8'($urandom), 1'b0, 1'b0);
					sent++;
				end
				send_word(8'($urandom), 1'b1, 1'b0);
			end
			send_word(8'($urandom), tail_byte, 1'b1);
			sent += len + 1;
		end
		in_valid <= 1'b0;

		@(negedge clk);
		wait (pending_words == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
